FILE: rtl/region_mask_blend_voxel_unit_macros.svh
// assertion helpers for the voxel blend unit
`ifndef REGION_MASK_BLEND_VOXEL_UNIT_MACROS_SVH
`define REGION_MASK_BLEND_VOXEL_UNIT_MACROS_SVH

// same-cycle implication, reset masked
`define RMBV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmbv check failed");

// next-cycle implication, reset masked
`define RMBV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmbv check failed");

`endif

FILE: rtl/rmbv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmbv_pkg;

  localparam int VALUE_W = 32;
  localparam int OUT_W   = 40;
  localparam int CFG_W   = 60;
  localparam int RAD_W   = 42;

  typedef enum logic [2:0] {
    OP_OVERWRITE = 3'd0,
    OP_ADD       = 3'd1,
    OP_SUB       = 3'd2,
    OP_MUL       = 3'd3,
    OP_DIV       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SHAPE_ALL    = 2'd0,
    SHAPE_BOX    = 2'd1,
    SHAPE_SPHERE = 2'd2,
    SHAPE_VOXEL  = 2'd3
  } shape_t;

  localparam logic [2:0] REG_OP       = 3'd0;
  localparam logic [2:0] REG_FILL_SRC = 3'd1;
  localparam logic [2:0] REG_SHAPE    = 3'd2;
  localparam logic [2:0] REG_DIMS     = 3'd3;
  localparam logic [2:0] REG_FILL     = 3'd4;
  localparam logic [2:0] REG_LOW      = 3'd5;
  localparam logic [2:0] REG_HIGH     = 3'd6;
  localparam logic [2:0] REG_RADIUS   = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0] res;
    logic               sat;
    logic               in_region;
    logic               is_div;
    logic               fill_zero;
    logic               cur_neg;
    logic               cur_zero;
    logic               neg;
  } blend_t;

  typedef struct packed {
    logic               sat;
    logic [VALUE_W-1:0] val;
  } clamp_t;

  function automatic clamp_t clamp_value(input logic neg, input logic [63:0] mag);
    clamp_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        r.sat = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.val = mag[31:0];
      end
    end else begin
      if (mag > 64'h8000_0000) begin
        r.sat = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = ~mag[31:0] + 32'd1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rmbv_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rmbv_front
  import rmbv_pkg::*;
#(
  parameter int COORD_BITS      = 12,
  parameter int VALUE_FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            ce,
  input  wire logic                            in_valid,
  input  wire logic [COORD_BITS-1:0]           x_coord,
  input  wire logic [COORD_BITS-1:0]           y_coord,
  input  wire logic [COORD_BITS-1:0]           z_coord,
  input  wire logic [VALUE_W-1:0]              current_value,
  input  wire logic [VALUE_W-1:0]              other_value,
  input  wire logic [2:0]                      operation_kind,
  input  wire logic                            fill_from_other,
  input  wire logic [1:0]                      shape_kind,
  input  wire logic [1:0]                      active_dimensions,
  input  wire logic [VALUE_W-1:0]              fill_constant,
  input  wire logic [CFG_W-1:0]                region_low,
  input  wire logic [CFG_W-1:0]                region_high,
  input  wire logic [RAD_W-1:0]                radius_squared,
  output logic                                 out_valid,
  output blend_t                               out_blend,
  output logic [VALUE_W+VALUE_FRAC_BITS-1:0]   out_dividend,
  output logic [VALUE_W-1:0]                   out_divisor
);

  localparam int FB  = COORD_BITS + 8;
  localparam int PW  = (3 * FB > CFG_W) ? 3 * FB : CFG_W;
  localparam int SW  = 2 * FB + 2;
  localparam int CW  = (SW > RAD_W) ? SW : RAD_W;

  logic [PW-1:0]      low_ext;
  logic [PW-1:0]      high_ext;
  logic [FB-1:0]      pos [3];
  logic [FB-1:0]      lo [3];
  logic [FB-1:0]      hi [3];
  logic [FB-1:0]      dlt [3];
  logic [VALUE_W-1:0] fill;
  logic [VALUE_W-1:0] magc;
  logic [VALUE_W-1:0] magf;

  // stage a registers
  logic               va;
  logic [2*FB-1:0]    sq [3];
  logic [2:0]         box_ok;
  logic [2:0]         eq_ok;
  logic [VALUE_W-1:0] cur_a;
  logic [VALUE_W-1:0] fill_a;
  logic [VALUE_W-1:0] magc_a;
  logic [VALUE_W-1:0] magf_a;
  logic [63:0]        prod_a;

  assign low_ext  = PW'(region_low);
  assign high_ext = PW'(region_high);
  assign pos[0]   = {x_coord, 8'd0};
  assign pos[1]   = {y_coord, 8'd0};
  assign pos[2]   = {z_coord, 8'd0};
  assign fill     = fill_from_other ? other_value : fill_constant;
  assign magc     = current_value[VALUE_W-1] ? (~current_value + 32'd1) : current_value;
  assign magf     = fill[VALUE_W-1] ? (~fill + 32'd1) : fill;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign lo[a]   = low_ext[a*FB +: FB];
    assign hi[a]   = high_ext[a*FB +: FB];
    assign dlt[a]  = (pos[a] >= lo[a]) ? (pos[a] - lo[a]) : (lo[a] - pos[a]);

    always_ff @(posedge clk) begin
      if (ce) begin
        sq[a]     <= dlt[a] * dlt[a];
        box_ok[a] <= (pos[a] >= lo[a]) && (pos[a] <= hi[a]);
        eq_ok[a]  <= (pos[a] == lo[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ce) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cur_a  <= current_value;
      fill_a <= fill;
      magc_a <= magc;
      magf_a <= magf;
      prod_a <= magc * magf;
    end
  end

  // stage b: region decision and the operations other than divide
  logic [1:0]          dims;
  logic [2:0]          act;
  logic [SW-1:0]       sum_sq;
  logic                in_region;
  logic [VALUE_W:0]    add_s;
  logic [VALUE_W:0]    sub_s;
  logic [VALUE_W:0]    add_n;
  logic [VALUE_W:0]    sub_n;
  logic [63:0]         add_m;
  logic [63:0]         sub_m;
  logic [63:0]         mul_m;
  logic                neg;
  clamp_t              cl;
  blend_t              blend_next;

  always_comb begin
    dims   = (active_dimensions == 2'd0) ? 2'd1 : active_dimensions;
    act    = {dims == 2'd3, dims >= 2'd2, 1'b1};
    sum_sq = SW'(sq[0]) + (act[1] ? SW'(sq[1]) : '0) + (act[2] ? SW'(sq[2]) : '0);
    case (shape_kind)
      SHAPE_BOX:    in_region = &(box_ok | ~act);
      SHAPE_SPHERE: in_region = CW'(sum_sq) < CW'(radius_squared);
      SHAPE_VOXEL:  in_region = &(eq_ok | ~act);
      default:      in_region = 1'b1;
    endcase

    neg   = cur_a[VALUE_W-1] ^ fill_a[VALUE_W-1];
    add_s = {cur_a[VALUE_W-1], cur_a} + {fill_a[VALUE_W-1], fill_a};
    sub_s = {cur_a[VALUE_W-1], cur_a} - {fill_a[VALUE_W-1], fill_a};
    add_n = -add_s;
    sub_n = -sub_s;
    add_m = add_s[VALUE_W] ? 64'(add_n) : 64'(add_s);
    sub_m = sub_s[VALUE_W] ? 64'(sub_n) : 64'(sub_s);
    mul_m = (prod_a + (64'd1 << (VALUE_FRAC_BITS - 1))) >> VALUE_FRAC_BITS;

    cl.sat = 1'b0;
    cl.val = cur_a;
    if (in_region) begin
      case (operation_kind)
        OP_OVERWRITE: cl.val = fill_a;
        OP_ADD:       cl = clamp_value(add_s[VALUE_W], add_m);
        OP_SUB:       cl = clamp_value(sub_s[VALUE_W], sub_m);
        OP_MUL:       cl = clamp_value(neg && (mul_m != 64'd0), mul_m);
        default:      cl.sat = 1'b0;
      endcase
    end

    blend_next.res       = cl.val;
    blend_next.sat       = cl.sat;
    blend_next.in_region = in_region;
    blend_next.is_div    = in_region && (operation_kind == OP_DIV);
    blend_next.fill_zero = (fill_a == '0);
    blend_next.cur_neg   = cur_a[VALUE_W-1];
    blend_next.cur_zero  = (cur_a == '0);
    blend_next.neg       = neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_blend    <= blend_next;
      out_dividend <= {magc_a, {VALUE_FRAC_BITS{1'b0}}};
      out_divisor  <= magf_a;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rmbv_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rmbv_div
  import rmbv_pkg::*;
#(
  parameter int VALUE_FRAC_BITS = 16,
  parameter int QW  = VALUE_W + VALUE_FRAC_BITS,
  parameter int DB  = 2,
  parameter int STG = (QW + DB - 1) / DB,
  parameter int DWP = STG * DB
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               ce,
  input  wire logic               in_valid,
  input  wire blend_t             in_blend,
  input  wire logic [QW-1:0]      dividend,
  input  wire logic [VALUE_W-1:0] divisor,
  output logic                    out_valid,
  output blend_t                  out_blend,
  output logic [DWP-1:0]          quotient
);

  logic               v   [STG];
  logic [VALUE_W-1:0] rem [STG];
  logic [DWP-1:0]     dvd [STG];
  logic [DWP-1:0]     quo [STG];
  logic [VALUE_W-1:0] dsr [STG];
  blend_t             pl  [STG];

  for (genvar i = 0; i < STG; i++) begin : g_stage
    logic               v_in;
    logic [VALUE_W-1:0] rem_in;
    logic [DWP-1:0]     dvd_in;
    logic [DWP-1:0]     quo_in;
    logic [VALUE_W-1:0] dsr_in;
    blend_t             pl_in;
    logic [VALUE_W-1:0] rem_next;
    logic [DWP-1:0]     dvd_next;
    logic [DWP-1:0]     quo_next;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign dvd_in = DWP'(dividend);
      assign quo_in = '0;
      assign dsr_in = divisor;
      assign pl_in  = in_blend;
    end else begin : g_next
      assign v_in   = v[i-1];
      assign rem_in = rem[i-1];
      assign dvd_in = dvd[i-1];
      assign quo_in = quo[i-1];
      assign dsr_in = dsr[i-1];
      assign pl_in  = pl[i-1];
    end

    // restoring division, DB quotient bits per stage
    always_comb begin
      logic [VALUE_W:0] t;
      rem_next = rem_in;
      dvd_next = dvd_in;
      quo_next = quo_in;
      for (int j = 0; j < DB; j++) begin
        t        = {rem_next, dvd_next[DWP-1]};
        dvd_next = dvd_next << 1;
        if (t >= {1'b0, dsr_in}) begin
          t        = t - {1'b0, dsr_in};
          quo_next = {quo_next[DWP-2:0], 1'b1};
        end else begin
          quo_next = {quo_next[DWP-2:0], 1'b0};
        end
        rem_next = t[VALUE_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (ce) begin
        v[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[i] <= rem_next;
        dvd[i] <= dvd_next;
        quo[i] <= quo_next;
        dsr[i] <= dsr_in;
        pl[i]  <= pl_in;
      end
    end
  end

  assign out_valid = v[STG-1];
  assign out_blend = pl[STG-1];
  assign quotient  = quo[STG-1];

endmodule
`default_nettype wire

FILE: rtl/region_mask_blend_voxel_unit.sv
// region_mask_blend_voxel_unit: masked update of a voxel field
//
// s_tdata carries one voxel per item: x, y, z coordinates, the current
// value and the other field's value. m_tdata returns one item per input:
// the new value and the inside, saturated and divide-by-zero flags.
// The cfg port writes one setup register per cycle at cfg_index; write
// it only while no items are in flight.
//
// One item is accepted per cycle while the pipeline is not held. Items
// pass the input register, front stages a and b, the restoring divider
// (two quotient bits per stage) and the output register.
//
// Reset clears every stage valid bit and loads the register defaults
// (overwrite, constant fill, region everywhere, one axis).
// When m_tready is low with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "region_mask_blend_voxel_unit_macros.svh"
module region_mask_blend_voxel_unit
  import rmbv_pkg::*;
#(
  parameter int COORD_BITS      = 12,
  parameter int VALUE_FRAC_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      s_tvalid,
  output logic                                           s_tready,
  // x_coord, y_coord, z_coord, current_value, other_value
  input  wire logic [((3*COORD_BITS+64+7)/8)*8-1:0]      s_tdata,
  output logic                                           m_tvalid,
  input  wire logic                                      m_tready,
  // new_value, was_inside, saturated, divided_by_zero
  output logic [OUT_W-1:0]                               m_tdata,
  input  wire logic                                      cfg_we,
  input  wire logic [2:0]                                cfg_index,
  input  wire logic [CFG_W-1:0]                          cfg_data
);

  localparam int CB  = COORD_BITS;
  localparam int QW  = VALUE_W + VALUE_FRAC_BITS;
  localparam int DB  = 2;
  localparam int STG = (QW + DB - 1) / DB;
  localparam int DWP = STG * DB;

  logic [2:0]         operation_kind;
  logic               fill_from_other;
  logic [1:0]         shape_kind;
  logic [1:0]         active_dimensions;
  logic [VALUE_W-1:0] fill_constant;
  logic [CFG_W-1:0]   region_low;
  logic [CFG_W-1:0]   region_high;
  logic [RAD_W-1:0]   radius_squared;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation_kind    <= OP_OVERWRITE;
      fill_from_other   <= 1'b0;
      shape_kind        <= SHAPE_ALL;
      active_dimensions <= 2'd1;
      fill_constant     <= '0;
      region_low        <= '0;
      region_high       <= '0;
      radius_squared    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OP:       operation_kind    <= cfg_data[2:0];
        REG_FILL_SRC: fill_from_other   <= cfg_data[0];
        REG_SHAPE:    shape_kind        <= cfg_data[1:0];
        REG_DIMS:     active_dimensions <= cfg_data[1:0];
        REG_FILL:     fill_constant     <= cfg_data[VALUE_W-1:0];
        REG_LOW:      region_low        <= cfg_data;
        REG_HIGH:     region_high       <= cfg_data;
        REG_RADIUS:   radius_squared    <= cfg_data[RAD_W-1:0];
        default:      radius_squared    <= radius_squared;
      endcase
    end
  end

  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // input register
  logic               v_in;
  logic [CB-1:0]      x_in;
  logic [CB-1:0]      y_in;
  logic [CB-1:0]      z_in;
  logic [VALUE_W-1:0] cur_in;
  logic [VALUE_W-1:0] oth_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else if (ce) begin
      v_in <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_in   <= s_tdata[0 +: CB];
      y_in   <= s_tdata[CB +: CB];
      z_in   <= s_tdata[2*CB +: CB];
      cur_in <= s_tdata[3*CB +: VALUE_W];
      oth_in <= s_tdata[3*CB+VALUE_W +: VALUE_W];
    end
  end

  logic               fr_valid;
  blend_t             fr_blend;
  logic [QW-1:0]      fr_dividend;
  logic [VALUE_W-1:0] fr_divisor;

  rmbv_front #(
    .COORD_BITS      (COORD_BITS),
    .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .ce                (ce),
    .in_valid          (v_in),
    .x_coord           (x_in),
    .y_coord           (y_in),
    .z_coord           (z_in),
    .current_value     (cur_in),
    .other_value       (oth_in),
    .operation_kind    (operation_kind),
    .fill_from_other   (fill_from_other),
    .shape_kind        (shape_kind),
    .active_dimensions (active_dimensions),
    .fill_constant     (fill_constant),
    .region_low        (region_low),
    .region_high       (region_high),
    .radius_squared    (radius_squared),
    .out_valid         (fr_valid),
    .out_blend         (fr_blend),
    .out_dividend      (fr_dividend),
    .out_divisor       (fr_divisor)
  );

  logic           dv_valid;
  blend_t         dv_blend;
  logic [DWP-1:0] dv_quot;

  rmbv_div #(
    .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
    .QW              (QW),
    .DB              (DB),
    .STG             (STG),
    .DWP             (DWP)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (fr_valid),
    .in_blend  (fr_blend),
    .dividend  (fr_dividend),
    .divisor   (fr_divisor),
    .out_valid (dv_valid),
    .out_blend (dv_blend),
    .quotient  (dv_quot)
  );

  // final select and clamp
  clamp_t cl;
  logic   dz;

  always_comb begin
    cl.sat = dv_blend.sat;
    cl.val = dv_blend.res;
    dz     = 1'b0;
    if (dv_blend.is_div) begin
      if (dv_blend.fill_zero) begin
        dz = 1'b1;
        if (dv_blend.cur_zero) begin
          cl.sat = 1'b0;
          cl.val = '0;
        end else begin
          cl = clamp_value(dv_blend.cur_neg, 64'd1 << 40);
        end
      end else begin
        cl = clamp_value(dv_blend.neg && (dv_quot != '0), 64'(dv_quot));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= {5'd0, dz, cl.sat, dv_blend.in_region, cl.val};
    end
  end

  `RMBV_ASSERT_IMP(a_dz_inside, m_tvalid && m_tdata[34], m_tdata[32])
  `RMBV_ASSERT_IMP(a_outside_clean, m_tvalid && !m_tdata[32], !m_tdata[33] && !m_tdata[34])
  `RMBV_ASSERT_NEXT(a_div_hold, dv_valid && !ce, dv_valid)
  `RMBV_ASSERT_NEXT(a_front_hold, fr_valid && !ce, fr_valid && $stable(fr_blend))

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rmbv_pkg::*;

  localparam int CB = 12;
  localparam int FB = 16;
  localparam int IN_W = ((3*CB+64+7)/8)*8;
  localparam int LATENCY = 4 + (32 + FB) / 2;

  typedef struct packed {
    logic        dz;
    logic        sat;
    logic        in_region;
    logic [31:0] value;
  } voxel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  region_mask_blend_voxel_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow of the setup registers
  logic [2:0]  op_reg;
  logic        fill_src_reg;
  logic [1:0]  shape_reg;
  logic [1:0]  dims_reg;
  logic [31:0] fill_reg;
  logic [59:0] low_reg;
  logic [59:0] high_reg;
  logic [41:0] radius_reg;

  voxel_result_t pending_results[$];
  int errors = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [19:0] region_axis(input logic [59:0] packed_v, input int a);
    return packed_v[a*20 +: 20];
  endfunction

  function automatic bit voxel_inside(input logic [19:0] pos[3]);
    int dims;
    logic [63:0] dsum;
    logic [19:0] c, d;
    dims = dims_reg == 0 ? 1 : dims_reg;
    dsum = 0;
    case (shape_reg)
      SHAPE_BOX: begin
        for (int a = 0; a < dims; a++)
          if (pos[a] < region_axis(low_reg, a) || pos[a] > region_axis(high_reg, a))
            return 0;
        return 1;
      end
      SHAPE_SPHERE: begin
        for (int a = 0; a < dims; a++) begin
          c = region_axis(low_reg, a);
          d = pos[a] >= c ? pos[a] - c : c - pos[a];
          dsum += 64'(d) * 64'(d);
        end
        return dsum < 64'(radius_reg);
      end
      SHAPE_VOXEL: begin
        for (int a = 0; a < dims; a++)
          if (pos[a] != region_axis(low_reg, a)) return 0;
        return 1;
      end
      default: return 1;
    endcase
  endfunction

  function automatic void saturate(input bit neg, input logic [63:0] m,
                                   output logic [31:0] v, inout logic s);
    if (!neg) begin
      if (m > 64'h7FFF_FFFF) begin s = 1; v = 32'h7FFF_FFFF; end
      else v = m[31:0];
    end else begin
      if (m > 64'h8000_0000) begin s = 1; v = 32'h8000_0000; end
      else v = -m[31:0];
    end
  endfunction

  function automatic voxel_result_t blend_voxel(input logic [IN_W-1:0] d);
    voxel_result_t r;
    logic [19:0] pos[3];
    logic signed [63:0] cur, fill, t;
    logic [63:0] p, m;
    bit neg;
    cur = $signed(d[3*CB +: 32]);
    fill = fill_src_reg ? $signed(d[3*CB+32 +: 32]) : $signed(fill_reg);
    for (int a = 0; a < 3; a++) pos[a] = {d[a*CB +: CB], 8'd0};
    r = '0;
    r.value = cur[31:0];
    r.in_region = voxel_inside(pos);
    if (r.in_region) begin
      neg = (cur < 0) != (fill < 0);
      case (op_reg)
        OP_OVERWRITE: r.value = fill[31:0];
        OP_ADD: begin
          t = cur + fill;
          saturate(t < 0, mag64(t), r.value, r.sat);
        end
        OP_SUB: begin
          t = cur - fill;
          saturate(t < 0, mag64(t), r.value, r.sat);
        end
        OP_MUL: begin
          p = mag64(cur) * mag64(fill);
          m = (p + (64'd1 << (FB-1))) >> FB;
          saturate(neg && m != 0, m, r.value, r.sat);
        end
        OP_DIV: begin
          if (fill == 0) begin
            r.dz = 1;
            if (cur == 0) r.value = 0;
            else saturate(cur < 0, 64'd1 << 40, r.value, r.sat);
          end else begin
            m = (mag64(cur) << FB) / mag64(fill);
            saturate(neg && m != 0, m, r.value, r.sat);
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    voxel_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[34:0];
      if (pending_results.size() == 0) begin
        $display("unexpected item %h at %0t", m_tdata, $realtime);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value) report_mismatch("new_value", got.value, want.value);
        if (got.in_region !== want.in_region)
          report_mismatch("was_inside", 32'(got.in_region), 32'(want.in_region));
        if (got.sat !== want.sat) report_mismatch("saturated", 32'(got.sat), 32'(want.sat));
        if (got.dz !== want.dz)
          report_mismatch("divided_by_zero", 32'(got.dz), 32'(want.dz));
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    int stall;
    if (rst) m_tready <= 1'b0;
    else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall = $urandom_range(1, 14);
      repeat (stall - 1) @(posedge clk);
    end else m_tready <= 1'b1;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_OP: op_reg = value[2:0];
      REG_FILL_SRC: fill_src_reg = value[0];
      REG_SHAPE: shape_reg = value[1:0];
      REG_DIMS: dims_reg = value[1:0];
      REG_FILL: fill_reg = value[31:0];
      REG_LOW: low_reg = value[59:0];
      REG_HIGH: high_reg = value[59:0];
      default: radius_reg = value[41:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // drives at the edge; valid stays high across back-to-back items
  task automatic send_voxel(input logic [11:0] x, input logic [11:0] y, input logic [11:0] z,
                            input logic [31:0] cur, input logic [31:0] oth);
    logic [IN_W-1:0] d;
    d = '0;
    d[0 +: 12] = x;
    d[12 +: 12] = y;
    d[24 +: 12] = z;
    d[36 +: 32] = cur;
    d[68 +: 32] = oth;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    pending_results.push_back(blend_voxel(d));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_input;
    s_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value;
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [59:0] rand_region;
    return {20'($urandom_range(0, 32'hF_FFFF)), 20'($urandom_range(0, 32'hF_FFFF)),
            20'($urandom_range(0, 32'hF_FFFF))};
  endfunction

  task automatic test_directed;
    // every operation with extreme operands, everywhere region
    for (int op = 0; op < 8; op++) begin
      write_reg(REG_OP, CFG_W'(op));
      write_reg(REG_FILL, CFG_W'(op[0] ? 32'h8000_0000 : 32'h7FFF_FFFF));
      send_voxel(12'hFFF, 12'h000, 12'hFFF, 32'h7FFF_FFFF, 32'h0);
      send_voxel(12'h000, 12'hFFF, 12'h000, 32'h8000_0000, 32'hFFFF_FFFF);
      idle_input();
      drain();
    end
    // divide by zero fill with positive, negative and zero value, then two divides by a nonzero fill
    write_reg(REG_OP, CFG_W'(OP_DIV));
    write_reg(REG_FILL_SRC, CFG_W'(1));
    send_voxel(12'd1, 12'd2, 12'd3, 32'h0001_0000, 32'd0);
    send_voxel(12'd1, 12'd2, 12'd3, 32'hFFFF_0000, 32'd0);
    send_voxel(12'd1, 12'd2, 12'd3, 32'd0, 32'd0);
    send_voxel(12'd1, 12'd2, 12'd3, 32'h8000_0000, 32'hFFFF_FFFF);
    send_voxel(12'd1, 12'd2, 12'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    idle_input();
    drain();
    // single voxel, zero dimensions, fractional position
    write_reg(REG_SHAPE, CFG_W'(SHAPE_VOXEL));
    write_reg(REG_DIMS, CFG_W'(0));
    write_reg(REG_LOW, {20'h0, 20'h0, 20'h00500});
    send_voxel(12'd5, 12'd7, 12'd9, 32'h0002_0000, 32'h0001_0000);
    send_voxel(12'd6, 12'd7, 12'd9, 32'h0002_0000, 32'h0001_0000);
    idle_input();
    drain();
    write_reg(REG_LOW, {20'h0, 20'h0, 20'h00580});
    send_voxel(12'd5, 12'd0, 12'd0, 32'h0002_0000, 32'h0001_0000);
    idle_input();
    drain();
  endtask

  task automatic test_random_regions;
    int n;
    for (int phase = 0; phase < 32; phase++) begin
      write_reg(REG_OP, CFG_W'($urandom_range(0, 7)));
      write_reg(REG_FILL_SRC, CFG_W'($urandom_range(0, 1)));
      write_reg(REG_SHAPE, CFG_W'($urandom_range(0, 3)));
      write_reg(REG_DIMS, CFG_W'($urandom_range(0, 3)));
      write_reg(REG_FILL, CFG_W'($urandom_range(0, 4) == 0 ? 32'd0 : rand_value()));
      write_reg(REG_LOW, phase == 0 ? 60'h0 : phase == 1 ? {60{1'b1}} : rand_region());
      write_reg(REG_HIGH, phase == 1 ? 60'h0 : phase == 2 ? {60{1'b1}} : rand_region());
      write_reg(REG_RADIUS, phase == 3 ? CFG_W'({42{1'b1}}) :
                CFG_W'({10'($urandom_range(0, 1023)), 32'($urandom())}));
      if (phase >= 28) begin
        send_gaps = 0;
        recv_gaps = 0;
      end
      n = 45 + $urandom_range(0, 10);
      for (int i = 0; i < n; i++) begin
        logic [11:0] cx, cy, cz;
        // half the voxels land near the region corner or center
        if ($urandom_range(0, 1)) begin
          cx = 12'(low_reg[19:8] + $urandom_range(0, 4) - 2);
          cy = 12'(low_reg[39:28] + $urandom_range(0, 4) - 2);
          cz = 12'(low_reg[59:48] + $urandom_range(0, 4) - 2);
        end else begin
          cx = 12'($urandom);
          cy = 12'($urandom);
          cz = 12'($urandom);
        end
        send_voxel(cx, cy, cz, rand_value(), $urandom_range(0, 4) == 0 ? 32'd0 : rand_value());
      end
      idle_input();
      drain();
    end
  endtask

  initial begin
    op_reg = OP_OVERWRITE;
    fill_src_reg = 0;
    shape_reg = SHAPE_ALL;
    dims_reg = 1;
    fill_reg = 0;
    low_reg = 0;
    high_reg = 0;
    radius_reg = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_regions();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
